### sv/mtpp_pkg.sv
// Package for the memory tier page placer: widths, codes, types.
`default_nettype none
package mtpp_pkg;
	localparam int TABLE_ENTRIES = 256;
	localparam int PAGE_BITS     = 12;
	localparam int ADDR_W        = 48;
	localparam int PAGE_W        = ADDR_W - PAGE_BITS;
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = 32;
	localparam logic [CNT_W-1:0] MAX32 = '1;

	localparam logic [1:0] OP_PLACE   = 2'd0;
	localparam logic [1:0] OP_ACCESS  = 2'd1;
	localparam logic [1:0] OP_MIGRATE = 2'd2;

	localparam logic [2:0] POL_RANGE  = 3'd0;
	localparam logic [2:0] POL_FIRST  = 3'd1;
	localparam logic [2:0] POL_HOTCLD = 3'd2;
	localparam logic [2:0] POL_INTLV  = 3'd3;
	localparam logic [2:0] POL_FAR    = 3'd5;

	localparam logic [2:0] REG_TIER_EN  = 3'd0;
	localparam logic [2:0] REG_POLICY   = 3'd1;
	localparam logic [2:0] REG_FAR_ADDR = 3'd2;
	localparam logic [2:0] REG_LCAP     = 3'd3;
	localparam logic [2:0] REG_FCAP     = 3'd4;
	localparam logic [2:0] REG_HOT_THR  = 3'd5;
	localparam logic [2:0] REG_RUN      = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_APPLY, ST_PROMO, ST_CHECK, ST_DEMO, ST_DONE
	} state_t;

	// One table slot: stored page, tier, flags, hit count.
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              tier;
		logic              hot;
		logic              cold;
		logic [CNT_W-1:0]  hits;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v == MAX32) ? v : v + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction
endpackage
`default_nettype wire

### sv/mtpp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module mtpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### sv/memory_tier_page_placer_core.sv
// Top level of the memory tier page placer.
// Each word on s_axis is one operation (place, record access, migrate) and
// gives exactly one word on m_axis. Place under a table policy and access
// with tiering on scan the page table one slot a cycle through a single
// RAM port; migrate under hot/cold makes one promotion pass and at most one
// demotion pass; other words finish without a table pass.
// s_axis_tready is low from acceptance until the result is taken.
// Slot valid bits live in flip-flops cleared by reset; no clearing pass.
`default_nettype none
module memory_tier_page_placer_core
	import mtpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: page_address[47:0]
	input  wire logic [47:0] s_axis_tdata,
	// tuser: opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: tier, page_known, table_full, local_used, far_used,
	// promoted_total, demoted_total, promote_fail_total (lowest first), 5 pad
	output logic [167:0]     m_axis_tdata
);
	// configuration
	logic              tier_en_q;
	logic [2:0]        policy_q;
	logic [ADDR_W-1:0] far_addr_q;
	logic [CNT_W-1:0]  lcap_q, fcap_q, thr_q, run_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_en_q  <= 1'b0;
			policy_q   <= POL_RANGE;
			far_addr_q <= 48'h1000_0000_0000;
			lcap_q     <= 32'd4194304;
			fcap_q     <= 32'd16777216;
			thr_q      <= 32'd1000;
			run_len_q  <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIER_EN:  tier_en_q  <= cfg_wdata[0];
				REG_POLICY:   policy_q   <= cfg_wdata[2:0];
				REG_FAR_ADDR: far_addr_q <= cfg_wdata;
				REG_LCAP:     lcap_q     <= cfg_wdata[CNT_W-1:0];
				REG_FCAP:     fcap_q     <= cfg_wdata[CNT_W-1:0];
				REG_HOT_THR:  thr_q      <= cfg_wdata[CNT_W-1:0];
				REG_RUN:      run_len_q  <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// far capacity only bounds overcommit, which is allowed anyway
	logic fcap_unused;
	assign fcap_unused = ^fcap_q;

	state_t state_q, state_d;
	logic [SLOT_W:0]   idx_q;
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic              found_q, free_q;
	logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]  local_q, far_q, run_cnt_q, promo_q, demo_q, refuse_q;
	logic              run_tier_q;
	logic              res_tier_q, res_known_q, res_full_q, out_v_q;
	logic              rd_v_q;       // RAM data of idx_q-1 valid this cycle
	logic [SLOT_W-1:0] rd_idx_q;

	// shared RAM port
	logic              ram_we;
	logic [SLOT_W-1:0] ram_addr;
	slot_t             ram_wd, ram_rd;
	logic [SLOT_BITS-1:0] ram_rd_bits;
	assign ram_rd = slot_t'(ram_rd_bits);

	mtpp_ram #(.WIDTH(SLOT_BITS), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(ram_wd), .rdata(ram_rd_bits)
	);

	logic [PAGE_W-1:0] page_w;
	assign page_w = addr_q[ADDR_W-1:PAGE_BITS];

	logic scan_end;
	assign scan_end = idx_q[SLOT_W];

	logic [35:0] cap9, cap8, loc10;
	assign loc10 = {4'd0, local_q} * 36'd10;
	assign cap9  = {4'd0, lcap_q} * 36'd9;
	assign cap8  = {4'd0, lcap_q} * 36'd8;
	logic room;
	assign room = {1'b0, local_q} + 33'd1 <= {1'b0, lcap_q};

	logic rd_slot_valid;
	assign rd_slot_valid = rd_v_q && valid_q[rd_idx_q];

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		ram_addr = idx_q[SLOT_W-1:0];
		ram_wd   = ram_rd;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (rd_v_q && !scan_end) state_d = ST_SCAN;
				if (!rd_v_q && scan_end) state_d = ST_APPLY;
				if (op_q == OP_MIGRATE) state_d = ST_PROMO;
			end
			ST_APPLY: begin
				ram_addr = found_q ? hit_idx_q : free_idx_q;
				state_d  = ST_DONE;
			end
			ST_PROMO: begin
				ram_we   = rd_slot_valid && ram_rd.hot && ram_rd.tier && room;
				ram_addr = ram_we ? rd_idx_q : idx_q[SLOT_W-1:0];
				ram_wd.tier = 1'b0;
				if (scan_end && !rd_v_q) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = (loc10 > cap9) ? ST_DEMO : ST_DONE;
			ST_DEMO: begin
				ram_we   = rd_slot_valid && ram_rd.cold && !ram_rd.tier &&
				           !(loc10 <= cap8);
				ram_addr = ram_we ? rd_idx_q : idx_q[SLOT_W-1:0];
				ram_wd.tier = 1'b1;
				if ((scan_end && !rd_v_q) || (rd_slot_valid && ram_rd.cold &&
				    !ram_rd.tier && loc10 <= cap8)) state_d = ST_DONE;
			end
			ST_DONE: if (!out_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// the write in APPLY comes from the apply_we/apply_wd logic below and
		// uses the same RAM port in that cycle
		if (state_q == ST_APPLY) begin
			ram_we = apply_we;
			ram_wd = apply_wd;
		end
	end

	logic  apply_we;
	slot_t apply_wd;
	logic  ap_tier, ap_new;
	logic [CNT_W-1:0] hits_inc;
	assign hits_inc = inc_sat(hit_rec_q.hits);
	slot_t hit_rec_q;

	always_comb begin
		ap_new = !found_q && free_q && op_q == OP_PLACE;
		unique case (policy_q)
			POL_FIRST:  ap_tier = !room;
			POL_HOTCLD: ap_tier = 1'b1;
			default:    ap_tier = run_tier_q;
		endcase
		apply_we = 1'b0;
		apply_wd = hit_rec_q;
		if (op_q == OP_PLACE) begin
			apply_we      = ap_new;
			apply_wd.page = page_w;
			apply_wd.tier = ap_tier;
			apply_wd.hot  = 1'b0;
			apply_wd.cold = (policy_q == POL_HOTCLD);
			apply_wd.hits = '0;
		end else if (found_q) begin
			apply_we      = 1'b1;
			apply_wd.hits = hits_inc;
			if (policy_q == POL_HOTCLD && !hit_rec_q.hot && hits_inc >= thr_q) begin
				apply_wd.hot  = 1'b1;
				apply_wd.cold = 1'b0;
			end
		end
	end

	logic table_op;
	assign table_op = tier_en_q && ((s_axis_tuser == OP_PLACE &&
		(s_axis_tuser == OP_PLACE) && (policy_q == POL_FIRST ||
		policy_q == POL_HOTCLD || policy_q == POL_INTLV)) ||
		s_axis_tuser == OP_ACCESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0; op_q <= OP_PLACE; addr_q <= '0;
			found_q <= 1'b0; free_q <= 1'b0; hit_idx_q <= '0; free_idx_q <= '0;
			valid_q <= '0; local_q <= '0; far_q <= '0; run_cnt_q <= '0;
			run_tier_q <= 1'b0; promo_q <= '0; demo_q <= '0; refuse_q <= '0;
			res_tier_q <= 1'b0; res_known_q <= 1'b0; res_full_q <= 1'b0;
			out_v_q <= 1'b0; rd_v_q <= 1'b0; rd_idx_q <= '0; hit_rec_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			rd_v_q   <= 1'b0;
			rd_idx_q <= ram_addr;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					op_q <= s_axis_tuser; addr_q <= s_axis_tdata;
					idx_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
					res_tier_q <= 1'b0; res_known_q <= 1'b0; res_full_q <= 1'b0;
					if (!table_op) begin
						// no scan: finish at once, or start the promotion pass for a hot/cold migrate
						if (s_axis_tuser == OP_MIGRATE && tier_en_q &&
						    policy_q == POL_HOTCLD) begin
							state_q <= ST_PROMO;
						end else begin
							state_q <= ST_DONE;
							out_v_q <= 1'b1;
							if (s_axis_tuser == OP_PLACE && tier_en_q)
								res_tier_q <= (policy_q == POL_RANGE) ?
									(s_axis_tdata >= far_addr_q) :
									(policy_q == POL_FAR);
						end
					end
				end
				ST_SCAN: begin
					if (!scan_end) begin
						idx_q <= idx_q + 1'b1; rd_v_q <= 1'b1;
					end
					if (rd_v_q) begin
						if (valid_q[rd_idx_q] && ram_rd.page == page_w && !found_q) begin
							found_q <= 1'b1; hit_idx_q <= rd_idx_q; hit_rec_q <= ram_rd;
						end
						if (!valid_q[rd_idx_q] && !free_q) begin
							free_q <= 1'b1; free_idx_q <= rd_idx_q;
						end
					end
					if (scan_end && !rd_v_q) state_q <= ST_APPLY;
					else state_q <= ST_SCAN;
				end
				ST_APPLY: begin
					out_v_q <= 1'b1;
					if (op_q == OP_PLACE) begin
						if (found_q) begin
							res_tier_q <= hit_rec_q.tier; res_known_q <= 1'b1;
						end else if (!free_q) begin
							res_full_q <= 1'b1;
						end else begin
							res_tier_q <= ap_tier;
							valid_q[free_idx_q] <= 1'b1;
							if (ap_tier) far_q <= inc_sat(far_q);
							else local_q <= inc_sat(local_q);
							if (policy_q == POL_INTLV) begin
								if (run_cnt_q + 1'b1 >= run_len_q) begin
									run_cnt_q <= '0; run_tier_q <= !run_tier_q;
								end else run_cnt_q <= run_cnt_q + 1'b1;
							end
						end
					end else if (found_q) begin
						res_tier_q <= hit_rec_q.tier; res_known_q <= 1'b1;
					end
				end
				ST_PROMO: begin
					if (!scan_end) begin
						idx_q <= idx_q + 1'b1; rd_v_q <= !ram_we;
						if (ram_we) idx_q <= idx_q;
					end
					if (rd_slot_valid && ram_rd.hot && ram_rd.tier) begin
						if (room) begin
							far_q <= dec_sat(far_q); local_q <= inc_sat(local_q);
							promo_q <= inc_sat(promo_q);
						end else refuse_q <= inc_sat(refuse_q);
					end
					if (scan_end && !rd_v_q) begin
						state_q <= ST_CHECK; idx_q <= '0;
					end else state_q <= ST_PROMO;
				end
				ST_CHECK: if (!(loc10 > cap9)) out_v_q <= 1'b1;
				ST_DEMO: begin
					if (!scan_end) begin
						idx_q <= idx_q + 1'b1; rd_v_q <= !ram_we;
						if (ram_we) idx_q <= idx_q;
					end
					if (ram_we) begin
						local_q <= dec_sat(local_q); far_q <= inc_sat(far_q);
						demo_q <= inc_sat(demo_q);
					end
					if (state_d == ST_DONE) out_v_q <= 1'b1;
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, refuse_q, demo_q, promo_q, far_q, local_q,
	                        res_full_q, res_known_q, res_tier_q};

	always_ff @(posedge clk) begin
		if (arst_n && out_v_q && !m_axis_tready && $past(arst_n) && $past(out_v_q))
			assert ($stable(m_axis_tdata)) else $error("result changed under stall");
	end
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result waits");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_full_q && res_known_q)) else $error("full and known");
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> scan_end) else $error("apply before scan end");
endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for memory_tier_page_placer_core.
`timescale 1ns / 1ps
module tb_top;
	import mtpp_pkg::*;

	// Codes with no package constant: all-local policy and the no-op opcode.
	localparam logic [2:0] POL_LOCAL = 3'd4;
	localparam logic [1:0] OP_NOP    = 2'd3;
	localparam int POOL_SIZE = 300;

	// One result word, unpacked.
	typedef struct {
		logic             tier;
		logic             known;
		logic             full;
		logic [CNT_W-1:0] local_used;
		logic [CNT_W-1:0] far_used;
		logic [CNT_W-1:0] promoted;
		logic [CNT_W-1:0] demoted;
		logic [CNT_W-1:0] refused;
	} placement_t;

	// A directed row: either a register write or a word, optionally with
	// tier/known/full typed in by hand.
	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [47:0] val;
		logic [1:0]  op;
		logic [47:0] addr;
		bit          typed;
		logic        t, k, f;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [47:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [167:0] m_axis_tdata;

	memory_tier_page_placer_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// ---- shadow of the block's registers and page table ----
	logic              en_q;
	logic [2:0]        pol_q;
	logic [47:0]       far_addr_q;
	logic [CNT_W-1:0]  lcap_q, fcap_q, thr_q, run_len_q;
	logic              tbl_valid [TABLE_ENTRIES];
	logic [PAGE_W-1:0] tbl_page  [TABLE_ENTRIES];
	logic              tbl_tier  [TABLE_ENTRIES];
	logic              tbl_hot   [TABLE_ENTRIES];
	logic              tbl_cold  [TABLE_ENTRIES];
	logic [CNT_W-1:0]  tbl_hits  [TABLE_ENTRIES];
	logic [CNT_W-1:0]  local_cnt, far_cnt, run_cnt, promo_cnt, demo_cnt, refuse_cnt;
	logic              run_tier;

	placement_t        placements_due[$];
	bit                typed_due[$];
	placement_t        typed_vals[$];
	row_t              dir_rows[$];
	logic [PAGE_W-1:0] pool [POOL_SIZE];
	int                errors = 0;
	bit                calm = 0;     // phase with no idling on either side
	bit                hold_req = 0; // asks the sink for one long hold-off

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == MAX32) ? v : v + 1;
	endfunction

	function automatic logic [CNT_W-1:0] drop(input logic [CNT_W-1:0] v);
		return (v == 0) ? v : v - 1;
	endfunction

	function automatic int slot_of(input logic [PAGE_W-1:0] pg);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_valid[i] && tbl_page[i] == pg)
				return i;
		return -1;
	endfunction

	function automatic bit room_local();
		return ({1'b0, local_cnt} + 33'd1) <= {1'b0, lcap_q};
	endfunction

	// Promotion pass then, above 90% local use, demotion of cold pages down to 80%.
	task automatic migrate_pass();
		longint unsigned cap;
		cap = lcap_q;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!tbl_valid[i] || !tbl_hot[i] || tbl_tier[i] == 1'b0)
				continue;
			if (!room_local()) begin
				refuse_cnt = bump(refuse_cnt);
				continue;
			end
			far_cnt = drop(far_cnt);
			local_cnt = bump(local_cnt);
			tbl_tier[i] = 1'b0;
			promo_cnt = bump(promo_cnt);
		end
		if (longint'(local_cnt) * 10 > cap * 9) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!tbl_valid[i] || !tbl_cold[i] || tbl_tier[i] != 1'b0)
					continue;
				if (longint'(local_cnt) * 10 <= cap * 8)
					break;
				local_cnt = drop(local_cnt);
				far_cnt = bump(far_cnt);
				tbl_tier[i] = 1'b1;
				demo_cnt = bump(demo_cnt);
			end
		end
	endtask

	// Works out the result word for one accepted word and updates the shadow.
	task automatic decide_tier(input logic [1:0] op, input logic [47:0] a,
			output placement_t r);
		int s;
		logic [PAGE_W-1:0] pg;
		logic cold;
		pg = a[47:PAGE_BITS];
		r.tier = 1'b0;
		r.known = 1'b0;
		r.full = 1'b0;
		if (op == OP_PLACE && en_q) begin
			if (pol_q == POL_RANGE) begin
				r.tier = (a >= far_addr_q);
			end else if (pol_q == POL_FAR) begin
				r.tier = 1'b1;
			end else if (pol_q >= POL_FIRST && pol_q <= POL_INTLV) begin
				s = slot_of(pg);
				if (s >= 0) begin
					r.tier = tbl_tier[s];
					r.known = 1'b1;
				end else begin
					s = -1;
					for (int i = 0; i < TABLE_ENTRIES && s < 0; i++)
						if (!tbl_valid[i])
							s = i;
					if (s < 0) begin
						r.full = 1'b1;
					end else begin
						cold = 1'b0;
						if (pol_q == POL_FIRST) begin
							r.tier = !room_local();
						end else if (pol_q == POL_HOTCLD) begin
							r.tier = 1'b1;
							cold = 1'b1;
						end else begin
							// interleave: a run length of zero behaves as one
							r.tier = run_tier;
							run_cnt = run_cnt + 1;
							if (run_cnt >= run_len_q) begin
								run_cnt = 0;
								run_tier = ~run_tier;
							end
						end
						if (r.tier == 1'b0)
							local_cnt = bump(local_cnt);
						else
							far_cnt = bump(far_cnt);
						tbl_valid[s] = 1'b1;
						tbl_page[s] = pg;
						tbl_tier[s] = r.tier;
						tbl_hot[s] = 1'b0;
						tbl_cold[s] = cold;
						tbl_hits[s] = 0;
					end
				end
			end
		end else if (op == OP_ACCESS && en_q) begin
			s = slot_of(pg);
			if (s >= 0) begin
				r.known = 1'b1;
				tbl_hits[s] = bump(tbl_hits[s]);
				if (pol_q == POL_HOTCLD && !tbl_hot[s] && tbl_hits[s] >= thr_q) begin
					tbl_hot[s] = 1'b1;
					tbl_cold[s] = 1'b0;
				end
				r.tier = tbl_tier[s];
			end
		end else if (op == OP_MIGRATE && en_q && pol_q == POL_HOTCLD) begin
			migrate_pass();
		end
		r.local_used = local_cnt;
		r.far_used = far_cnt;
		r.promoted = promo_cnt;
		r.demoted = demo_cnt;
		r.refused = refuse_cnt;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("ERROR %t %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// ---- clock, reset, limit ----
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#60ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---- sink: random hold-off per word, one long hold on request ----
	initial begin
		int n;
		placement_t got, want;
		placement_t tv;
		bit typed;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 19);
			if (hold_req) begin
				// long stall counted here while the source keeps offering words
				n = 700;
				hold_req = 0;
			end
			if (n > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			got.tier = m_axis_tdata[0];
			got.known = m_axis_tdata[1];
			got.full = m_axis_tdata[2];
			got.local_used = m_axis_tdata[34:3];
			got.far_used = m_axis_tdata[66:35];
			got.promoted = m_axis_tdata[98:67];
			got.demoted = m_axis_tdata[130:99];
			got.refused = m_axis_tdata[162:131];
			if (placements_due.size() == 0) begin
				report("result word with nothing outstanding", m_axis_tdata[63:0], 0);
				continue;
			end
			want = placements_due.pop_front();
			typed = typed_due.pop_front();
			tv = typed_vals.pop_front();
			if (got.tier !== want.tier) report("tier", got.tier, want.tier);
			if (got.known !== want.known) report("page_known", got.known, want.known);
			if (got.full !== want.full) report("table_full", got.full, want.full);
			if (got.local_used !== want.local_used)
				report("local_used", got.local_used, want.local_used);
			if (got.far_used !== want.far_used) report("far_used", got.far_used, want.far_used);
			if (got.promoted !== want.promoted)
				report("promoted_total", got.promoted, want.promoted);
			if (got.demoted !== want.demoted) report("demoted_total", got.demoted, want.demoted);
			if (got.refused !== want.refused)
				report("promote_fail_total", got.refused, want.refused);
			// hand-typed directed values: all three flags must match as written
			if (typed && {got.tier, got.known, got.full} !== {tv.tier, tv.known, tv.full})
				report("directed flags", {got.tier, got.known, got.full},
					{tv.tier, tv.known, tv.full});
		end
	end

	// ---- source side ----
	// Offer one word after a random gap; prediction is made at acceptance.
	task automatic send_word(input logic [1:0] op, input logic [47:0] a,
			input bit typed, input logic t, input logic k, input logic f);
		int gap;
		placement_t r, tv;
		gap = calm ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= a;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		decide_tier(op, a, r);
		tv = r;
		tv.tier = t;
		tv.known = k;
		tv.full = f;
		placements_due.push_back(r);
		typed_due.push_back(typed);
		typed_vals.push_back(tv);
	endtask

	// Drop valid and wait until every result has come back, then let the
	// block finish whatever it is doing.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (placements_due.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIER_EN:  en_q = v[0];
			REG_POLICY:   pol_q = v[2:0];
			REG_FAR_ADDR: far_addr_q = v;
			REG_LCAP:     lcap_q = v[31:0];
			REG_FCAP:     fcap_q = v[31:0];
			REG_HOT_THR:  thr_q = v[31:0];
			REG_RUN:      run_len_q = v[31:0];
			default: ;
		endcase
	endtask

	function automatic logic [47:0] any_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// Random words over a window of the page pool; some noise addresses.
	task automatic run_phase(input int n, input int base, input int span, input bit wide);
		int r;
		logic [1:0] op;
		logic [47:0] a;
		logic [11:0] off;
		calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 45) ? OP_PLACE : (r < 85) ? OP_ACCESS : (r < 96) ? OP_MIGRATE : OP_NOP;
			off = $urandom;
			if (wide || $urandom_range(0, 9) == 0)
				a = any_addr();
			else
				a = {pool[base + $urandom_range(0, span - 1)], off};
			// range policy: now and then straddle the boundary
			if (wide && $urandom_range(0, 3) == 0)
				a = far_addr_q + 48'($signed($urandom_range(0, 4)) - 2);
			send_word(op, a, 1'b0, 1'b0, 1'b0, 1'b0);
		end
		calm = 0;
	endtask

	function automatic void add_cfg(input logic [2:0] idx, input logic [47:0] v);
		row_t w;
		w = '{1'b1, idx, v, OP_NOP, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0};
		dir_rows.push_back(w);
	endfunction

	function automatic void add_op(input logic [1:0] op, input logic [47:0] a,
			input bit typed, input logic t, input logic k, input logic f);
		row_t w;
		w = '{1'b0, 3'd0, 48'd0, op, a, typed, t, k, f};
		dir_rows.push_back(w);
	endfunction

	initial begin
		logic [63:0] w;
		// reset values of the shadow
		en_q = 1'b0;
		pol_q = POL_RANGE;
		far_addr_q = 48'h1000_0000_0000;
		lcap_q = 32'd4194304;
		fcap_q = 32'd16777216;
		thr_q = 32'd1000;
		run_len_q = 32'd1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_page[i] = '0;
			tbl_tier[i] = 1'b0;
			tbl_hot[i] = 1'b0;
			tbl_cold[i] = 1'b0;
			tbl_hits[i] = '0;
		end
		{local_cnt, far_cnt, run_cnt, promo_cnt, demo_cnt, refuse_cnt} = '0;
		run_tier = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			w = {$urandom, $urandom};
			pool[i] = w[PAGE_W-1:0];
		end

		// Directed table. Tiering off after reset: everything local, nothing known.
		add_op(OP_PLACE, 48'h0, 1, 0, 0, 0);
		add_op(OP_ACCESS, 48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);
		add_op(OP_MIGRATE, 48'h0, 1, 0, 0, 0);
		add_op(OP_NOP, 48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);
		add_cfg(REG_TIER_EN, 48'd1);
		// range policy either side of the default boundary, then its extremes
		add_op(OP_PLACE, 48'h0FFF_FFFF_FFFF, 1, 0, 0, 0);
		add_op(OP_PLACE, 48'h1000_0000_0000, 1, 1, 0, 0);
		add_cfg(REG_FAR_ADDR, 48'h0);
		add_op(OP_PLACE, 48'h0, 1, 1, 0, 0);
		add_cfg(REG_FAR_ADDR, 48'hFFFF_FFFF_FFFF);
		add_op(OP_PLACE, 48'hFFFF_FFFF_FFFF, 1, 1, 0, 0);
		add_op(OP_PLACE, 48'hFFFF_FFFF_FFFE, 1, 0, 0, 0);
		// fixed-tier policies; codes six and seven fall back to all local
		add_cfg(REG_POLICY, POL_FAR);
		add_op(OP_PLACE, 48'h0, 1, 1, 0, 0);
		add_cfg(REG_POLICY, POL_LOCAL);
		add_op(OP_PLACE, 48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);
		add_cfg(REG_POLICY, 48'd6);
		add_op(OP_PLACE, 48'h5000, 1, 0, 0, 0);
		add_cfg(REG_POLICY, 48'd7);
		add_op(OP_PLACE, 48'h6000, 1, 0, 0, 0);
		// first touch with room for one page, then overcommit past zero far room
		add_cfg(REG_LCAP, 48'd1);
		add_cfg(REG_FCAP, 48'd0);
		add_cfg(REG_POLICY, POL_FIRST);
		add_op(OP_PLACE, 48'h1000, 1, 0, 0, 0);
		add_op(OP_PLACE, 48'h1FFF, 1, 0, 1, 0);
		add_op(OP_PLACE, 48'h2000, 1, 1, 0, 0);
		add_op(OP_ACCESS, 48'h1ABC, 1, 0, 1, 0);
		add_op(OP_ACCESS, 48'hFFFF_FFFF_F000, 1, 0, 0, 0);
		// hot/cold: unreachable threshold, then zero threshold and promotion
		add_cfg(REG_POLICY, POL_HOTCLD);
		add_cfg(REG_HOT_THR, 48'hFFFF_FFFF);
		add_op(OP_PLACE, 48'h3000, 1, 1, 0, 0);
		add_op(OP_ACCESS, 48'h3000, 1, 1, 1, 0);
		add_op(OP_MIGRATE, 48'h0, 1, 0, 0, 0);
		add_cfg(REG_HOT_THR, 48'd0);
		add_op(OP_ACCESS, 48'h3000, 1, 1, 1, 0);
		add_op(OP_MIGRATE, 48'h0, 0, 0, 0, 0); // local full: refused
		add_cfg(REG_LCAP, 48'hFFFF_FFFF);
		add_op(OP_MIGRATE, 48'h0, 0, 0, 0, 0);
		add_op(OP_ACCESS, 48'h3000, 1, 0, 1, 0);
		// interleave with the longest run
		add_cfg(REG_FCAP, 48'hFFFF_FFFF);
		add_cfg(REG_RUN, 48'hFFFF_FFFF);
		add_cfg(REG_POLICY, POL_INTLV);
		add_op(OP_PLACE, 48'h4000, 1, 0, 0, 0);
		add_op(OP_NOP, 48'h4000, 1, 0, 0, 0);

		@(posedge arst_n);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			else
				send_word(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].typed,
					dir_rows[i].t, dir_rows[i].k, dir_rows[i].f);
		end

		// first touch, little local room
		write_reg(REG_LCAP, 48'd5);
		write_reg(REG_POLICY, POL_FIRST);
		run_phase(250, 0, 40, 0);

		// hot/cold with a low threshold; one long sink stall part way
		write_reg(REG_LCAP, 48'd12);
		write_reg(REG_HOT_THR, 48'd2);
		write_reg(REG_POLICY, POL_HOTCLD);
		run_phase(100, 40, 40, 0);
		hold_req = 1;
		run_phase(200, 0, 80, 0);

		write_reg(REG_RUN, 48'd3);
		write_reg(REG_POLICY, POL_INTLV);
		run_phase(200, 80, 40, 0);

		// hot on first access; the source pauses until all results are back
		write_reg(REG_LCAP, 48'd30);
		write_reg(REG_HOT_THR, 48'd0);
		write_reg(REG_POLICY, POL_HOTCLD);
		run_phase(125, 0, 120, 0);
		drain();
		run_phase(125, 0, 120, 0);

		// address-only policies and tiering off
		write_reg(REG_FAR_ADDR, any_addr());
		write_reg(REG_POLICY, POL_RANGE);
		run_phase(150, 0, 120, 1);
		write_reg(REG_POLICY, 48'($urandom_range(4, 7)));
		run_phase(100, 0, 120, 1);
		write_reg(REG_TIER_EN, 48'd0);
		run_phase(100, 0, 120, 0);

		// interleave on fresh pages until the table overflows
		write_reg(REG_TIER_EN, 48'd1);
		write_reg(REG_RUN, 48'd0);
		write_reg(REG_POLICY, POL_INTLV);
		run_phase(300, 120, 180, 0);

		write_reg(REG_LCAP, 48'hFFFF_FFFF);
		write_reg(REG_FCAP, 48'd0);
		write_reg(REG_HOT_THR, 48'd1);
		write_reg(REG_POLICY, POL_HOTCLD);
		run_phase(200, 0, POOL_SIZE, 0);

		drain();
		repeat (600) @(posedge clk);
		if (errors == 0 && placements_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
